### src/texel_signature_hash_core_macros.svh
// Assertion macros for the texel signature hash core.
`ifndef TEXEL_SIGNATURE_HASH_CORE_MACROS_SVH
`define TEXEL_SIGNATURE_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSH_ASSERT_NOW(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSH_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tsh_pkg.sv
// Package with constants, types and the hash mix function of the texel signature hash core.
package tsh_pkg;

	localparam int TEXEL_W   = 4;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W   = 23;
	localparam int HASH_W    = 64;
	localparam int LEVELS    = 16;
	localparam int BIN_W     = 4;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 96;

	localparam int DEFAULT_MAX_SIDE = 2048;

	localparam logic [HASH_W-1:0]  FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(LEVELS - 1);

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [HASH_W-1:0]  hash_t;

	// Xor in, then multiply by the prime 2^40 + 0x1b3 using shifts and adds.
	function automatic hash_t fnv_mix(hash_t h, hash_t v);
		hash_t x;
		x = h ^ v;
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic hash_t seed_of(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		return fnv_mix(FNV_BASIS, {36'd0, w, 4'd0, h});
	endfunction

endpackage

### src/texel_signature_hash_core.sv
// Texel signature hash core: run hash, level histogram and per-bin result drain.
// One texel is taken per cycle; the run hash (FNV-1a over texel pairs, seeded from the
// configured region size) and the 16-bin histogram update in the cycle of the transaction.
// The final texel copies counts and hash into an output bank and clears the run, so the
// next region streams in at once; its 16 results then leave one per cycle while the
// receiver is ready. A final texel waits only while a previous bank still holds
// undelivered results, so the input takes one texel per cycle but for such a wait.
`include "texel_signature_hash_core_macros.svh"

module texel_signature_hash_core #(
	parameter int MAX_SIDE = tsh_pkg::DEFAULT_MAX_SIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [tsh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsh_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tsh_pkg::S_DATA_W-1:0]    s_tdata,  // texel[3:0], zero[7:4]
	input  logic                            s_tlast,  // final_texel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tsh_pkg::M_DATA_W-1:0]    m_tdata,  // bin_index[3:0], bin_count[26:4],
	                                                  // signature[90:27], zero[95:91]
	output logic                            m_tlast   // end_of_run
);
	import tsh_pkg::*;

	localparam longint unsigned SideSq = longint'(MAX_SIDE) * longint'(MAX_SIDE);
	localparam count_t CountCap = (SideSq > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(SideSq);
	localparam logic [CFG_W:0] SideLim = (CFG_W + 1)'(MAX_SIDE);
	localparam hash_t ResetSeed = seed_of('0, '0);

	logic [CFG_W-1:0]   width_q, height_q, cfg_clamped;
	hash_t              seed_q, hash_q, hash_next;
	logic [TEXEL_W-1:0] held_q, texel;
	logic               half_q, run_open_q;
	count_t             cnt_q [LEVELS];
	count_t             cnt_next [LEVELS];
	count_t             snap_cnt_q [LEVELS];
	hash_t              snap_hash_q;
	logic               drain_active_q;
	logic [BIN_W-1:0]   drain_idx_q;
	logic               in_take, out_take, out_done, final_take;

	assign texel       = s_tdata[TEXEL_W-1:0];
	assign cfg_clamped = ({1'b0, cfg_wdata} > SideLim) ? SideLim[CFG_W-1:0] : cfg_wdata;

	assign out_take   = m_tvalid && m_tready;
	assign out_done   = out_take && (drain_idx_q == LAST_BIN);
	assign s_tready   = !(s_tlast && drain_active_q && !out_done);
	assign in_take    = s_tvalid && s_tready;
	assign final_take = in_take && s_tlast;

	always_comb begin
		if (half_q) begin
			hash_next = fnv_mix(hash_q, {56'd0, texel, held_q});
		end else if (run_open_q) begin
			hash_next = hash_q;
		end else begin
			hash_next = seed_q;
		end
		for (int i = 0; i < LEVELS; i++) begin
			cnt_next[i] = cnt_q[i];
			if ((texel == BIN_W'(i)) && (cnt_q[i] < CountCap)) begin
				cnt_next[i] = cnt_q[i] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			seed_q   <= ResetSeed;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_clamped;
					seed_q  <= seed_of(cfg_clamped, height_q);
				end
				REG_HEIGHT: begin
					height_q <= cfg_clamped;
					seed_q   <= seed_of(width_q, cfg_clamped);
				end
				default: begin
					seed_q <= seed_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= '0;
			held_q     <= '0;
			half_q     <= 1'b0;
			run_open_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (final_take) begin
			hash_q     <= '0;
			held_q     <= '0;
			half_q     <= 1'b0;
			run_open_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (in_take) begin
			hash_q     <= hash_next;
			held_q     <= half_q ? '0 : texel;
			half_q     <= !half_q;
			run_open_q <= 1'b1;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i] <= cnt_next[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (final_take) begin
			snap_hash_q <= hash_next;
			for (int i = 0; i < LEVELS; i++) begin
				snap_cnt_q[i] <= cnt_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_active_q <= 1'b0;
			drain_idx_q    <= '0;
		end else if (final_take) begin
			drain_active_q <= 1'b1;
			drain_idx_q    <= '0;
		end else if (out_take) begin
			drain_active_q <= !out_done;
			drain_idx_q    <= drain_idx_q + 1'b1;
		end
	end

	assign m_tvalid = drain_active_q;
	assign m_tlast  = (drain_idx_q == LAST_BIN);
	assign m_tdata  = {5'd0, snap_hash_q, snap_cnt_q[drain_idx_q], drain_idx_q};

	`TSH_ASSERT_NOW(a_final_waits_for_drain, clk, arst_n,
		final_take && drain_active_q, m_tready && (drain_idx_q == LAST_BIN),
		"final texel accepted over an undelivered result bank")

	`TSH_ASSERT_NEXT(a_drain_starts, clk, arst_n,
		final_take, m_tvalid && (drain_idx_q == '0),
		"result drain did not start at bin zero after the final texel")

	`TSH_ASSERT_NEXT(a_run_cleared, clk, arst_n,
		final_take, !half_q && !run_open_q,
		"run state not cleared after the final texel")

	`TSH_ASSERT_NEXT(a_drain_holds, clk, arst_n,
		m_tvalid && !m_tready, m_tvalid && $stable(drain_idx_q),
		"result drain moved while the result was stalled")

endmodule

### tb/texel_signature_hash_core_tb.sv
// Self-checking testbench for the texel signature hash core: directed and random regions.
module texel_signature_hash_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsh_pkg::*;

	localparam int            SIDE_LIMIT = DEFAULT_MAX_SIDE;
	localparam logic [63:0]   HASH_PRIME = 64'h100000001b3;
	localparam longint        SIDE_SQ    = longint'(SIDE_LIMIT) * longint'(SIDE_LIMIT);
	localparam count_t        COUNT_CAP  = (SIDE_SQ > longint'(COUNT_MAX)) ? COUNT_MAX :
	                                       count_t'(SIDE_SQ);
	localparam int            RANDOM_ITEMS = 200;

	typedef struct {
		logic [TEXEL_W-1:0] level;
		logic               fin;
	} texel_item_t;

	typedef struct {
		logic [BIN_W-1:0] bin;
		count_t           count;
		hash_t            sig;
		logic             eor;
	} bin_result_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;

	texel_item_t texels_to_send[$];
	bin_result_t bins_due[$];
	int          bad_cnt = 0;
	int          staged  = 0;

	// predictor state
	logic [CFG_W-1:0]   size_w = '0;
	logic [CFG_W-1:0]   size_h = '0;
	hash_t              sig_acc = '0;
	logic [TEXEL_W-1:0] held_level = '0;
	logic               pair_half = 1'b0;
	logic               run_live = 1'b0;
	count_t             level_hist[LEVELS];

	texel_signature_hash_core #(.MAX_SIDE(SIDE_LIMIT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic hash_t fold_byte(hash_t h, hash_t v);
		return (h ^ v) * HASH_PRIME;
	endfunction

	function automatic logic [CFG_W-1:0] clamp_side(logic [CFG_W-1:0] v);
		return (v > CFG_W'(SIDE_LIMIT)) ? CFG_W'(SIDE_LIMIT) : v;
	endfunction

	task automatic clear_region();
		sig_acc    = '0;
		held_level = '0;
		pair_half  = 1'b0;
		run_live   = 1'b0;
		for (int k = 0; k < LEVELS; k++)
			level_hist[k] = '0;
	endtask

	task automatic absorb_texel(input logic [TEXEL_W-1:0] t, input logic fin);
		bin_result_t r;
		if (!run_live) begin
			sig_acc  = fold_byte(FNV_BASIS, ({52'd0, size_w} << 16) | {52'd0, size_h});
			run_live = 1'b1;
		end
		if (pair_half) begin
			sig_acc    = fold_byte(sig_acc, {56'd0, t, held_level});
			pair_half  = 1'b0;
			held_level = '0;
		end else begin
			held_level = t;
			pair_half  = 1'b1;
		end
		if (level_hist[t] < COUNT_CAP)
			level_hist[t] = level_hist[t] + 1'b1;
		if (fin) begin
			for (int k = 0; k < LEVELS; k++) begin
				r.bin   = BIN_W'(k);
				r.count = level_hist[k];
				r.sig   = sig_acc;
				r.eor   = (k == LEVELS - 1);
				bins_due.push_back(r);
			end
			clear_region();
		end
	endtask

	initial clear_region();

	// track register writes and accepted texels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen) begin
				if (cfg_index == REG_WIDTH)
					size_w = clamp_side(cfg_wdata);
				else if (cfg_index == REG_HEIGHT)
					size_h = clamp_side(cfg_wdata);
			end
			if (s_tvalid && s_tready)
				absorb_texel(s_tdata[TEXEL_W-1:0], s_tlast);
		end
	end

	// sender: bursts of random length with random gaps
	int          burst_left = 0;
	int          idle_left  = 0;
	texel_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tlast    <= 1'b0;
			burst_left <= 0;
			idle_left  <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (idle_left != 0) begin
				s_tvalid  <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (texels_to_send.size() != 0) begin
				next_item = texels_to_send.pop_front();
				s_tvalid  <= 1'b1;
				s_tdata   <= {{(S_DATA_W-TEXEL_W){1'b0}}, next_item.level};
				s_tlast   <= next_item.fin;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 24);
					idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern that steps through four modes by ready_phase[7:6]
	logic [7:0] ready_phase = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			ready_phase <= '0;
		end else begin
			ready_phase <= ready_phase + 1'b1;
			case (ready_phase[7:6])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= (ready_phase[1:0] == 2'd0);
				default: m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	bin_result_t want;
	bin_result_t got;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.bin   = m_tdata[3:0];
			got.count = m_tdata[26:4];
			got.sig   = m_tdata[90:27];
			got.eor   = m_tlast;
			if (bins_due.size() == 0) begin
				if (bad_cnt < 10)
					$display("unexpected result: bin %0d count %0d sig %h last %b",
						got.bin, got.count, got.sig, got.eor);
				bad_cnt++;
			end else begin
				want = bins_due.pop_front();
				if (got.bin !== want.bin || got.count !== want.count ||
				    got.sig !== want.sig || got.eor !== want.eor) begin
					if (bad_cnt < 10)
						$display("mismatch: exp bin %0d count %0d sig %h last %b, got bin %0d count %0d sig %h last %b",
							want.bin, want.count, want.sig, want.eor,
							got.bin, got.count, got.sig, got.eor);
					bad_cnt++;
				end
			end
		end
	end

	task automatic stage(input logic [TEXEL_W-1:0] t, input logic fin);
		texel_item_t it;
		it.level = t;
		it.fin   = fin;
		texels_to_send.push_back(it);
		staged++;
	endtask

	task automatic write_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		@(negedge clk);
	endtask

	// hold until every queued texel is taken and every result has arrived
	task automatic wait_quiet();
		@(negedge clk);
		while (texels_to_send.size() != 0 || s_tvalid || bins_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_side();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_W'(SIDE_LIMIT);
			2: return '1;
			3: return CFG_W'($urandom_range(1, 64));
			default: return CFG_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic stage_region(input int n, input logic fin);
		logic [TEXEL_W-1:0] bias;
		bit                 skewed;
		bias   = TEXEL_W'($urandom_range(0, 15));
		skewed = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++)
			stage((skewed && $urandom_range(0, 3) != 0) ? bias : TEXEL_W'($urandom),
				fin && (i == n - 1));
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// region of one texel under the reset size
		stage(4'd0, 1'b1);
		wait_quiet();

		// odd count at the largest size
		write_size(CFG_W'(SIDE_LIMIT), CFG_W'(SIDE_LIMIT));
		stage(4'd15, 1'b0);
		stage(4'd0, 1'b0);
		stage(4'd7, 1'b1);
		wait_quiet();

		// clamped width, every level once
		write_size(12'hfff, 12'd1);
		for (int i = 0; i < LEVELS; i++)
			stage(TEXEL_W'(i), i == LEVELS - 1);
		wait_quiet();

		// size change inside an open region keeps the old seed
		write_size(12'd5, 12'd7);
		stage(4'd9, 1'b0);
		stage(4'd3, 1'b0);
		wait_quiet();
		write_size(12'd100, 12'd200);
		stage(4'd12, 1'b1);
		wait_quiet();

		while (staged < RANDOM_ITEMS + 23) begin
			if ($urandom_range(0, 2) == 0)
				write_size(pick_side(), pick_side());
			repeat ($urandom_range(1, 4)) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
				stage_region(n, 1'b1);
			end
			if ($urandom_range(0, 4) == 0)
				stage_region($urandom_range(1, 3), 1'b0);
			wait_quiet();
		end
		stage_region($urandom_range(1, 6), 1'b1);
		wait_quiet();

		repeat (20) @(posedge clk);
		if (bad_cnt == 0 && bins_due.size() == 0)
			$display("texel_signature_hash_core_tb OK");
		else
			$display("texel_signature_hash_core_tb NOT OK");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("texel_signature_hash_core_tb NOT OK");
		$finish;
	end

endmodule
